@@ sv/nmea_sentence_checksum_classifier_defines.svh @@
// Assertion helpers used by the top-level RTL file.
`ifndef NMEA_SENTENCE_CHECKSUM_CLASSIFIER_DEFINES_SVH
`define NMEA_SENTENCE_CHECKSUM_CLASSIFIER_DEFINES_SVH

// Clocked check, disabled while reset is asserted.
`define NSCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that also holds during reset.
`define NSCC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/nscc_pkg.sv @@
`default_nettype none
package nscc_pkg;

    localparam int LINE_MAX  = 120;
    localparam int CNT_W     = 7;
    localparam int HDR_LEN   = 6;
    localparam int TAIL_LEN  = 5;

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_NUL  = 8'h00;

    typedef logic [2:0] kind_t;
    localparam kind_t KIND_OTHER = 3'd0;
    localparam kind_t KIND_GGA   = 3'd1;
    localparam kind_t KIND_GSA   = 3'd2;
    localparam kind_t KIND_GSV   = 3'd3;
    localparam kind_t KIND_RMC   = 3'd4;
    localparam kind_t KIND_VTG   = 3'd5;

    // index 0 is the first byte of the line
    typedef logic [HDR_LEN-1:0][7:0]  hdr_t;
    // index 0 is the oldest byte
    typedef logic [TAIL_LEN-1:0][7:0] tail_t;

    // strings are reversed so that '$' lands at index 0
    localparam hdr_t HDR_GGA = "AGGNG$";
    localparam hdr_t HDR_GSA = "ASGNG$";
    localparam hdr_t HDR_GSV = "VSGPG$";
    localparam hdr_t HDR_RMC = "CMRNG$";
    localparam hdr_t HDR_VTG = "GTVNG$";

    typedef struct packed {
        logic [CNT_W-1:0] eff_len;
        logic [7:0]       xsum;
        tail_t            tail;
        hdr_t             hdr;
    } line_t;

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c[3:0];
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

@@ sv/nscc_eval.sv @@
`default_nettype none
module nscc_eval (
    input  var nscc_pkg::line_t line,
    output logic                checksum_ok,
    output nscc_pkg::kind_t     sentence_kind
);
    import nscc_pkg::*;

    logic [7:0] want;

    assign want = {hex_val(line.tail[1]), hex_val(line.tail[2])};

    always_comb
    begin
        checksum_ok = (line.eff_len >= CNT_W'(TAIL_LEN)) && (line.tail[0] == CH_STAR)
                      && (want == line.xsum);
        sentence_kind = KIND_OTHER;
        if (checksum_ok)
        begin
            if (line.hdr == HDR_GGA)
            begin
                sentence_kind = KIND_GGA;
            end
            else if (line.hdr == HDR_GSA)
            begin
                sentence_kind = KIND_GSA;
            end
            else if (line.hdr == HDR_GSV)
            begin
                sentence_kind = KIND_GSV;
            end
            else if (line.hdr == HDR_RMC)
            begin
                sentence_kind = KIND_RMC;
            end
            else if (line.hdr == HDR_VTG)
            begin
                sentence_kind = KIND_VTG;
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/nmea_sentence_checksum_classifier.sv @@
// NMEA sentence checksum checker and classifier.
// Input stream: one received byte per request on s_tdata. A linefeed ends the
// line; a line reaching 120 bytes without one is dropped with no result.
// Output stream: one result per linefeed on m_tdata (checksum flag and
// sentence kind: 0 other/failed, 1 GGA, 2 GSA, 3 GSV, 4 RMC, 5 VTG).
// Throughput: one byte per cycle, unless a linefeed stalls (see Stall). The
// running XOR, a five-byte tail shift register and a six-byte header register
// are updated by a single combinational step between the input register and
// the result register. Result path: a linefeed is taken into the input
// register, then its verdict is loaded into the output register (m_tvalid).
// Stall: a finished result waits in the output register while other bytes
// keep flowing; only a linefeed that reaches the input register while the
// previous result is still held stops s_tready.
// Reset: rst_n clears the line state, the input register and the output
// valid; the block is ready as soon as reset is released.
`default_nettype none
`include "nmea_sentence_checksum_classifier_defines.svh"
module nmea_sentence_checksum_classifier (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [0] checksum_ok, [3:1] sentence_kind, [7:4] zero
);
    import nscc_pkg::*;

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             is_lf;
    logic             advance;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] eff_len_reg, eff_len_next;
    logic             zero_seen_reg, zero_seen_next;
    logic [7:0]       xsum_reg, xsum_next;
    tail_t            tail_reg, tail_next;
    hdr_t             hdr_reg, hdr_next;
    logic             line_done;

    line_t            line_next;
    logic             ok;
    kind_t            kind;

    logic             out_valid_reg;
    logic             out_ok_reg;
    kind_t            out_kind_reg;

    assign is_lf    = (in_byte_reg == CH_LF);
    assign advance  = in_valid_reg && (!is_lf || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        hdr_next       = hdr_reg;
        tail_next      = tail_reg;
        xsum_next      = xsum_reg;
        eff_len_next   = eff_len_reg;
        zero_seen_next = zero_seen_reg;
        if (count_reg < CNT_W'(HDR_LEN))
        begin
            hdr_next[count_reg[2:0]] = in_byte_reg;
        end
        if (!zero_seen_reg)
        begin
            if (in_byte_reg == CH_NUL)
            begin
                zero_seen_next = 1'b1;
            end
            else
            begin
                if (eff_len_reg >= CNT_W'(HDR_LEN))
                begin
                    xsum_next = xsum_reg ^ tail_reg[0];
                end
                tail_next    = {in_byte_reg, tail_reg[TAIL_LEN-1:1]};
                eff_len_next = eff_len_reg + 1'b1;
            end
        end
        count_next = count_reg + 1'b1;
        line_done  = is_lf || (count_next >= CNT_W'(LINE_MAX));
    end

    assign line_next = '{eff_len: eff_len_next, xsum: xsum_next,
                         tail: tail_next, hdr: hdr_next};

    nscc_eval u_eval (
        .line          (line_next),
        .checksum_ok   (ok),
        .sentence_kind (kind)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_byte_reg   <= '0;
            count_reg     <= '0;
            eff_len_reg   <= '0;
            zero_seen_reg <= 1'b0;
            xsum_reg      <= '0;
            tail_reg      <= '0;
            hdr_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_kind_reg  <= KIND_OTHER;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
                if (s_tvalid)
                begin
                    in_byte_reg <= s_tdata;
                end
            end

            if (advance)
            begin
                if (line_done)
                begin
                    count_reg     <= '0;
                    eff_len_reg   <= '0;
                    zero_seen_reg <= 1'b0;
                    xsum_reg      <= '0;
                    tail_reg      <= '0;
                    hdr_reg       <= '0;
                end
                else
                begin
                    count_reg     <= count_next;
                    eff_len_reg   <= eff_len_next;
                    zero_seen_reg <= zero_seen_next;
                    xsum_reg      <= xsum_next;
                    tail_reg      <= tail_next;
                    hdr_reg       <= hdr_next;
                end
            end

            if (advance && is_lf)
            begin
                out_valid_reg <= 1'b1;
                out_ok_reg    <= ok;
                out_kind_reg  <= kind;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_kind_reg, out_ok_reg};

    `NSCC_ASSERT(a_kind_needs_ok, m_tvalid |-> (out_ok_reg || out_kind_reg == KIND_OTHER), "sentence kind set on a failed checksum")
    `NSCC_ASSERT(a_kind_range, m_tvalid |-> (out_kind_reg <= KIND_VTG), "sentence kind out of range")
    `NSCC_ASSERT(a_lf_gives_result, (advance && is_lf) |=> m_tvalid, "linefeed taken without a result")
    `NSCC_ASSERT(a_overflow_clears, (advance && !is_lf && count_reg == CNT_W'(LINE_MAX - 1)) |=> (count_reg == '0), "overlong line not dropped")
    `NSCC_ASSERT(a_len_bound, (eff_len_reg <= count_reg) && (count_reg < CNT_W'(LINE_MAX)), "line counters inconsistent")

endmodule
`default_nettype wire

@@ tb/sv/tb_nmea_sentence_checksum_classifier.sv @@
`default_nettype none
module tb_nmea_sentence_checksum_classifier;
    import nscc_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_BYTES = 900;
    localparam int DIR_ROWS = 16;
    localparam logic [7:0] CR_BYTE = 8'h0D;

    typedef struct packed {
        logic  ok;
        kind_t kind;
    } verdict_t;

    // one directed line: text, then filler digits, optional byte overwrite,
    // optional '*', checksum and CR, optional linefeed
    typedef struct packed {
        logic [7:0] pad;
        logic       add_sum;
        logic       poke;
        logic [6:0] poke_at;
        logic [7:0] poke_val;
        logic       lf;
        logic       typed;
        logic       ok;
        kind_t      kind;
    } dir_row_t;

    string dir_text [DIR_ROWS] = '{
        "",
        "$GNGGA,123519,4807.038,N",
        "$GNGSA,A,3,04,05",
        "$GPGSV,3,1,11",
        "$GNRMC,225446,A",
        "$GNVTG,054.7,T",
        "$GPGGA,1",
        "$GNGSA",
        "$GNGGA,1*00\r",
        "*00",
        "$GNGSA*ab\r",
        "$GNRMC,#",
        "$GNGGA,1",
        "$GNVTG,1",
        "$GNGGA",
        "$GNRMC,"
    };

    // pad, sum, poke, at, value, lf, typed, ok, kind
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{8'd0,   1'b0, 1'b0, 7'd0, 8'h00, 1'b1, 1'b1, 1'b0, KIND_OTHER},
        '{8'd0,   1'b1, 1'b0, 7'd0, 8'h00, 1'b1, 1'b1, 1'b1, KIND_GGA},
        '{8'd0,   1'b1, 1'b0, 7'd0, 8'h00, 1'b1, 1'b1, 1'b1, KIND_GSA},
        '{8'd0,   1'b1, 1'b0, 7'd0, 8'h00, 1'b1, 1'b1, 1'b1, KIND_GSV},
        '{8'd0,   1'b1, 1'b0, 7'd0, 8'h00, 1'b1, 1'b1, 1'b1, KIND_RMC},
        '{8'd0,   1'b1, 1'b0, 7'd0, 8'h00, 1'b1, 1'b1, 1'b1, KIND_VTG},
        '{8'd0,   1'b1, 1'b0, 7'd0, 8'h00, 1'b1, 1'b1, 1'b1, KIND_OTHER},
        '{8'd0,   1'b1, 1'b0, 7'd0, 8'h00, 1'b1, 1'b1, 1'b1, KIND_GSA},
        '{8'd0,   1'b0, 1'b0, 7'd0, 8'h00, 1'b1, 1'b0, 1'b0, KIND_OTHER},
        '{8'd0,   1'b0, 1'b0, 7'd0, 8'h00, 1'b1, 1'b1, 1'b0, KIND_OTHER},
        '{8'd0,   1'b0, 1'b0, 7'd0, 8'h00, 1'b1, 1'b0, 1'b0, KIND_OTHER},
        '{8'd0,   1'b1, 1'b1, 7'd7, 8'hC5, 1'b1, 1'b1, 1'b1, KIND_RMC},
        '{8'd0,   1'b1, 1'b1, 7'd3, 8'h00, 1'b1, 1'b1, 1'b0, KIND_OTHER},
        '{8'd0,   1'b1, 1'b1, 7'd7, 8'h00, 1'b1, 1'b0, 1'b0, KIND_OTHER},
        '{8'd114, 1'b0, 1'b0, 7'd0, 8'h00, 1'b0, 1'b0, 1'b0, KIND_OTHER},
        '{8'd108, 1'b1, 1'b0, 7'd0, 8'h00, 1'b1, 1'b1, 1'b1, KIND_RMC}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] rx_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;   // [0] checksum_ok, [3:1] sentence_kind, [7:4] zero

    // sentence tracker state
    logic [6:0] ln_count;
    logic [6:0] ln_eff;
    logic       ln_nul;
    logic [7:0] ln_xor;
    logic [7:0] ln_tail [TAIL_LEN];
    logic [7:0] ln_head [HDR_LEN];

    verdict_t   verdict_q [$];
    verdict_t   got_exp;
    logic [7:0] line_buf [$];
    int         fail_count = 0;
    int         cycle_count = 0;
    int         hold_left = 0;
    bit         hold_go = 1'b0;
    bit         hold_taken = 1'b0;
    bit         calm = 1'b0;

    nmea_sentence_checksum_classifier u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return 4'(c - "0");
        end
        if (c >= "A" && c <= "F")
        begin
            return 4'(c - "A" + 8'd10);
        end
        return 4'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    function automatic kind_t header_kind();
        case ({ln_head[0], ln_head[1], ln_head[2], ln_head[3], ln_head[4], ln_head[5]})
            "$GNGGA": return KIND_GGA;
            "$GNGSA": return KIND_GSA;
            "$GPGSV": return KIND_GSV;
            "$GNRMC": return KIND_RMC;
            "$GNVTG": return KIND_VTG;
            default:  return KIND_OTHER;
        endcase
    endfunction

    task automatic sentence_clear();
        int i;
        ln_count = '0;
        ln_eff = '0;
        ln_nul = 1'b0;
        ln_xor = '0;
        for (i = 0; i < TAIL_LEN; i++)
        begin
            ln_tail[i] = '0;
        end
        for (i = 0; i < HDR_LEN; i++)
        begin
            ln_head[i] = '0;
        end
    endtask

    // advance the sentence tracker by one byte; done marks a linefeed
    task automatic sentence_take(input logic [7:0] b, output bit done, output verdict_t v);
        int i;
        done = 1'b0;
        v.ok = 1'b0;
        v.kind = KIND_OTHER;
        if (ln_count < HDR_LEN)
        begin
            ln_head[ln_count[2:0]] = b;
        end
        if (!ln_nul)
        begin
            if (b == CH_NUL)
            begin
                ln_nul = 1'b1;
            end
            else
            begin
                // byte leaving the tail is past the checksum window
                if (ln_eff >= 6)
                begin
                    ln_xor = ln_xor ^ ln_tail[0];
                end
                for (i = 0; i < TAIL_LEN - 1; i++)
                begin
                    ln_tail[i] = ln_tail[i+1];
                end
                ln_tail[TAIL_LEN-1] = b;
                ln_eff = ln_eff + 7'd1;
            end
        end
        ln_count = ln_count + 7'd1;
        if (b == CH_LF)
        begin
            done = 1'b1;
            if (ln_eff >= 5 && ln_tail[0] == CH_STAR &&
                {digit_value(ln_tail[1]), digit_value(ln_tail[2])} == ln_xor)
            begin
                v.ok = 1'b1;
                v.kind = header_kind();
            end
            sentence_clear();
        end
        else if (ln_count >= LINE_MAX)
        begin
            sentence_clear();
        end
    endtask

    // called at a falling edge, returns at the falling edge after the request
    task automatic send_byte(input logic [7:0] b, input bit typed, input verdict_t typed_v);
        bit       done;
        verdict_t v;
        while (!calm && $urandom_range(99) < 18)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sentence_take(b, done, v);
        if (done)
        begin
            verdict_q.push_back(typed ? typed_v : v);
        end
        @(negedge clk);
    endtask

    task automatic send_line(input bit typed, input logic ok, input kind_t kind);
        int       i;
        bit       last;
        verdict_t tv;
        tv.ok = ok;
        tv.kind = kind;
        for (i = 0; i < line_buf.size(); i++)
        begin
            last = (i == line_buf.size() - 1) && (line_buf[i] == CH_LF);
            send_byte(line_buf[i], typed && last, tv);
        end
    endtask

    task automatic append_sum();
        logic [7:0] x;
        int         i;
        x = 8'h00;
        for (i = 1; i < line_buf.size(); i++)
        begin
            x = x ^ line_buf[i];
        end
        line_buf.push_back(CH_STAR);
        line_buf.push_back(hex_char(x[7:4]));
        line_buf.push_back(hex_char(x[3:0]));
        line_buf.push_back(CR_BYTE);
    endtask

    task automatic build_random_line();
        int         mode;
        int         flaw;
        int         n;
        int         i;
        string      hdr;
        logic [7:0] c;
        line_buf.delete();
        mode = $urandom_range(99);
        if (mode < 8)
        begin
            // raw noise, linefeeds included
            n = $urandom_range(1, 30);
            repeat (n) line_buf.push_back(8'($urandom_range(255)));
        end
        else if (mode < 12)
        begin
            n = $urandom_range(0, 4);
            repeat (n) line_buf.push_back(printable());
            line_buf.push_back(CH_LF);
        end
        else if (mode < 14)
        begin
            // runs past the line limit before the linefeed
            n = $urandom_range(LINE_MAX, LINE_MAX + 6);
            repeat (n)
            begin
                c = 8'($urandom_range(255));
                line_buf.push_back((c == CH_LF) ? CH_STAR : c);
            end
            line_buf.push_back(CH_LF);
        end
        else
        begin
            case ($urandom_range(5))
                0:       hdr = "$GNGGA";
                1:       hdr = "$GNGSA";
                2:       hdr = "$GPGSV";
                3:       hdr = "$GNRMC";
                4:       hdr = "$GNVTG";
                default: hdr = "$GPGGA";
            endcase
            if ($urandom_range(5) == 0)
            begin
                hdr.putc($urandom_range(1, 5), 8'($urandom_range(8'h41, 8'h5A)));
            end
            for (i = 0; i < hdr.len(); i++)
            begin
                line_buf.push_back(hdr[i]);
            end
            n = $urandom_range(0, 30);
            repeat (n)
            begin
                c = ($urandom_range(24) == 0) ? 8'($urandom_range(128, 255)) : printable();
                line_buf.push_back(c);
            end
            append_sum();
            flaw = $urandom_range(99);
            if (flaw < 70)
            begin
                n = 0;
            end
            else if (flaw < 77)
            begin
                line_buf[line_buf.size()-3] = line_buf[line_buf.size()-3] ^ 8'h01;
            end
            else if (flaw < 83)
            begin
                for (i = line_buf.size() - 3; i < line_buf.size() - 1; i++)
                begin
                    if (line_buf[i] >= "A")
                    begin
                        line_buf[i] = line_buf[i] + 8'h20;
                    end
                end
            end
            else if (flaw < 87)
            begin
                void'(line_buf.pop_back());
            end
            else if (flaw < 91)
            begin
                line_buf[$urandom_range(6, line_buf.size() - 1)] = CH_NUL;
            end
            else if (flaw < 95)
            begin
                // zero ends the line after the CR and an 'X', rest is ignored
                line_buf.push_back("X");
                line_buf.push_back(CH_NUL);
                repeat ($urandom_range(0, 3)) line_buf.push_back(printable());
            end
            else
            begin
                line_buf[$urandom_range(0, HDR_LEN - 1)] = CH_NUL;
            end
            line_buf.push_back(CH_LF);
        end
    endtask

    // receiver: random back-pressure plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_go && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (calm)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= 18);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("unexpected result: m_tdata %h", m_tdata);
                fail_count++;
            end
            else
            begin
                got_exp = verdict_q.pop_front();
                if (m_tdata[0] !== got_exp.ok)
                begin
                    $error("checksum_ok: expected %0d, got %0d", got_exp.ok, m_tdata[0]);
                    fail_count++;
                end
                if (m_tdata[3:1] !== got_exp.kind)
                begin
                    $error("sentence_kind: expected %0d, got %0d", got_exp.kind, m_tdata[3:1]);
                    fail_count++;
                end
                if (m_tdata[7:4] !== 4'd0)
                begin
                    $error("pad: expected 0, got %0d", m_tdata[7:4]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int    r;
        int    i;
        int    line_no;
        int    sent;
        string txt;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        sentence_clear();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < DIR_ROWS; r++)
        begin
            line_buf.delete();
            txt = dir_text[r];
            for (i = 0; i < txt.len(); i++)
            begin
                line_buf.push_back(txt[i]);
            end
            repeat (dir_rows[r].pad) line_buf.push_back("7");
            if (dir_rows[r].poke)
            begin
                line_buf[dir_rows[r].poke_at] = dir_rows[r].poke_val;
            end
            if (dir_rows[r].add_sum)
            begin
                append_sum();
            end
            if (dir_rows[r].lf)
            begin
                line_buf.push_back(CH_LF);
            end
            send_line(dir_rows[r].typed, dir_rows[r].ok, dir_rows[r].kind);
        end

        line_no = 0;
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            // output stalls for a long stretch; input keeps offering lines
            if (line_no == 12)
            begin
                hold_go = 1'b1;
            end
            calm = (line_no >= 18 && line_no < 32);
            build_random_line();
            send_line(1'b0, 1'b0, KIND_OTHER);
            sent += line_buf.size();
            line_no++;
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (verdict_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
